// File: src/detection_track_table_core_defines.svh
// Assertion macros shared by the track table RTL.
// Expects clk_i and rst_ni in the including module.
`ifndef DETECTION_TRACK_TABLE_CORE_DEFINES_SVH
`define DETECTION_TRACK_TABLE_CORE_DEFINES_SVH

// condition must never hold
`define DTT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dtt: forbidden condition");

// antecedent implies consequent in the next cycle
`define DTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtt: sequence violated");

`endif

// File: src/dtt_pkg.sv
// Types and constants for the detection track table.
// No dependencies.
package dtt_pkg;

  localparam int MaxTracks = 16;
  localparam int CntW      = $clog2(MaxTracks + 1);

  typedef struct packed {
    logic       action;
    logic [9:0] box_x;
    logic [9:0] box_y;
    logic [9:0] box_width;
    logic [9:0] box_height;
    logic [2:0] class_label;
  } dtt_in_t;

  typedef struct packed {
    logic       present;
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [9:0] out_width;
    logic [9:0] out_height;
    logic [2:0] out_label;
    logic [2:0] hit_count;
    logic       overflow;
    logic       last;
  } dtt_out_t;

  typedef struct packed {
    logic       valid;
    logic       pending;
    logic       matched;
    logic [2:0] label;
    logic [4:0] hist;
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] w;
    logic [9:0] h;
  } dtt_entry_t;

  typedef struct packed {
    logic det;
    logic age;
    logic compact;
    logic rotate;
  } dtt_ctl_t;

endpackage

// File: src/dtt_cell.sv
// One slot of the track chain: match, insert, age, compaction and rotation.
// Depends on dtt_pkg.
module dtt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtt_pkg::dtt_ctl_t  ctl_i,
  input  dtt_pkg::dtt_in_t   det_i,
  input  logic [19:0]        lim2_i,
  input  logic [2:0]         min_hits_i,
  input  logic               hit_any_i,
  input  dtt_pkg::dtt_entry_t nxt_i,
  input  logic               prv_occ_i,
  input  logic               hole_i,
  output dtt_pkg::dtt_entry_t ent_o,
  output logic               occ_o,
  output logic               hole_o,
  output logic               hit_o,
  output logic               qual_o,
  output logic [2:0]         hits_o
);

  dtt_pkg::dtt_entry_t ent_q, ent_d;
  logic signed [10:0] ddx, ddy;
  logic [9:0]  adx, ady;
  logic [19:0] sqx, sqy;
  logic [20:0] d2;
  logic        ovl_x, ovl_y, near, same, ins;

  assign ddx = $signed({1'b0, det_i.box_x}) - $signed({1'b0, ent_q.x});
  assign ddy = $signed({1'b0, det_i.box_y}) - $signed({1'b0, ent_q.y});
  assign adx = ddx[10] ? 10'(-ddx) : ddx[9:0];
  assign ady = ddy[10] ? 10'(-ddy) : ddy[9:0];
  assign sqx = {10'd0, adx} * {10'd0, adx};
  assign sqy = {10'd0, ady} * {10'd0, ady};
  assign d2  = {1'b0, sqx} + {1'b0, sqy};
  assign near = d2 < {1'b0, lim2_i};

  assign ovl_x = (det_i.box_width != 10'd0) && (ent_q.w != 10'd0)
              && ({1'b0, ent_q.x} < ({1'b0, det_i.box_x} + {1'b0, det_i.box_width}))
              && ({1'b0, det_i.box_x} < ({1'b0, ent_q.x} + {1'b0, ent_q.w}));
  assign ovl_y = (det_i.box_height != 10'd0) && (ent_q.h != 10'd0)
              && ({1'b0, ent_q.y} < ({1'b0, det_i.box_y} + {1'b0, det_i.box_height}))
              && ({1'b0, det_i.box_y} < ({1'b0, ent_q.y} + {1'b0, ent_q.h}));
  assign same = (ovl_x && ovl_y) || near;

  assign occ_o  = ent_q.valid | ent_q.pending;
  assign hit_o  = ctl_i.det && ent_q.valid && !ent_q.matched
               && (ent_q.label == det_i.class_label) && same;
  assign ins    = ctl_i.det && !hit_any_i && !occ_o && prv_occ_i;
  assign hole_o = hole_i | !(ent_q.valid && (ent_q.hist != 5'd0));
  assign hits_o = 3'(ent_q.hist[0]) + 3'(ent_q.hist[1]) + 3'(ent_q.hist[2])
                + 3'(ent_q.hist[3]) + 3'(ent_q.hist[4]);
  assign qual_o = ent_q.valid && (hits_o >= min_hits_i);
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (hit_o) begin
      ent_d.x       = det_i.box_x;
      ent_d.y       = det_i.box_y;
      ent_d.w       = det_i.box_width;
      ent_d.h       = det_i.box_height;
      ent_d.hist    = {ent_q.hist[3:0], 1'b1};
      ent_d.matched = 1'b1;
    end else if (ins) begin
      ent_d.x       = det_i.box_x;
      ent_d.y       = det_i.box_y;
      ent_d.w       = det_i.box_width;
      ent_d.h       = det_i.box_height;
      ent_d.label   = det_i.class_label;
      ent_d.hist    = 5'd0;
      ent_d.pending = 1'b1;
    end else if (ctl_i.age) begin
      if (ent_q.valid) begin
        ent_d.hist = ent_q.matched ? ent_q.hist : {ent_q.hist[3:0], 1'b0};
      end else if (ent_q.pending) begin
        ent_d.valid = 1'b1;
        ent_d.hist  = 5'd1;
      end
      ent_d.matched = 1'b0;
      ent_d.pending = 1'b0;
    end else if ((ctl_i.compact && hole_o) || ctl_i.rotate) begin
      ent_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

// File: src/detection_track_table_core.sv
// Detection track table: a chain of track cells with an end-of-frame sequencer.
// End of frame: the accepting cycle ages the table, then the table is compacted, then
// the report rotates the chain one step per report cycle while the output does not
// stall, or gives a single empty report when no track qualifies. Input is stalled
// until the report finishes. Reset clears all tracks and flags; it sets the squared
// distance limit to 400 and the minimum hit count to 3.
module detection_track_table_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dtt_pkg::dtt_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dtt_pkg::dtt_out_t out_res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [9:0]        cfg_data_i
);

  `include "detection_track_table_core_defines.svh"

  localparam int N = dtt_pkg::MaxTracks;
  localparam int W = dtt_pkg::CntW;
  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StCompact = 2'd1;
  localparam logic [1:0] StReport  = 2'd2;
  localparam logic       CfgDist   = 1'b0;
  localparam logic       CfgMinHit = 1'b1;

  logic [1:0]  state_q, state_d;
  logic [W-1:0] cnt_q, cnt_d;
  logic [19:0] lim2_q;
  logic [2:0]  min_hits_q;
  logic        drop_q, drop_d;
  logic        out_valid_q, out_valid_d;
  dtt_pkg::dtt_out_t out_q, out_d;
  dtt_pkg::dtt_ctl_t ctl;
  logic        accept, out_free, out_load, hit_any, rest_qual;

  dtt_pkg::dtt_entry_t ent [N];
  dtt_pkg::dtt_entry_t nxt [N];
  logic [N-1:0] occ, hole, hit, qual;
  logic [2:0]   hits [N];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != StIdle;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign hit_any     = |hit;

  always_comb begin
    rest_qual = 1'b0;
    for (int j = 1; j < N; j++) begin
      if (W'(j) < cnt_q) rest_qual = rest_qual | qual[j];
    end
  end

  always_comb begin
    ctl.det     = accept && !in_req_i.action;
    ctl.age     = accept && in_req_i.action;
    ctl.compact = state_q == StCompact;
    ctl.rotate  = (state_q == StReport) && out_free
               && !((cnt_q == W'(N)) && (qual == '0));
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      assign nxt[i] = ctl.rotate ? ent[0] : '0;
    end else begin : g_mid
      assign nxt[i] = ent[i+1];
    end
    dtt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .det_i      (in_req_i),
      .lim2_i     (lim2_q),
      .min_hits_i (min_hits_q),
      .hit_any_i  (hit_any),
      .nxt_i      (nxt[i]),
      .prv_occ_i  ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
      .hole_i     ((i == 0) ? 1'b0 : hole[(i == 0) ? 0 : i-1]),
      .ent_o      (ent[i]),
      .occ_o      (occ[i]),
      .hole_o     (hole[i]),
      .hit_o      (hit[i]),
      .qual_o     (qual[i]),
      .hits_o     (hits[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    out_load = 1'b0;
    out_d    = out_q;
    if (ctl.det && !hit_any && occ[N-1]) drop_d = 1'b1;
    case (state_q)
      StIdle: begin
        if (ctl.age) begin
          state_d = StCompact;
          cnt_d   = W'(N);
        end
      end
      StCompact: begin
        cnt_d = cnt_q - W'(1);
        if (cnt_q == W'(1)) begin
          state_d = StReport;
          cnt_d   = W'(N);
        end
      end
      StReport: begin
        if (out_free) begin
          if ((cnt_q == W'(N)) && (qual == '0)) begin
            out_load = 1'b1;
            out_d    = '0;
            out_d.overflow = drop_q;
            out_d.last     = 1'b1;
            state_d  = StIdle;
            drop_d   = 1'b0;
          end else begin
            if (qual[0]) begin
              out_load         = 1'b1;
              out_d.present    = 1'b1;
              out_d.out_x      = ent[0].x;
              out_d.out_y      = ent[0].y;
              out_d.out_width  = ent[0].w;
              out_d.out_height = ent[0].h;
              out_d.out_label  = ent[0].label;
              out_d.hit_count  = hits[0];
              out_d.overflow   = drop_q;
              out_d.last       = !rest_qual;
            end
            cnt_d = cnt_q - W'(1);
            if (cnt_q == W'(1)) begin
              state_d = StIdle;
              drop_d  = 1'b0;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      lim2_q      <= 20'd400;
      min_hits_q  <= 3'd3;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == CfgDist) begin
        lim2_q <= {10'd0, cfg_data_i} * {10'd0, cfg_data_i};
      end
      if (cfg_valid_i && cfg_index_i == CfgMinHit) begin
        min_hits_q <= cfg_data_i[2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `DTT_ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && out_stall_i)
  `DTT_ASSERT_NEVER(a_occ_prefix, (state_q == StIdle) && !$onehot0(occ ^ {occ[N-2:0], 1'b1}))
  `DTT_ASSERT_NEXT(a_eof_compacts, ctl.age, (state_q == StCompact) && (cnt_q == W'(N)))

endmodule

// File: test/tb_top.sv
// Self-checking testbench for detection_track_table_core: detections and end-of-frame
// requests with random gaps and output stalls, checked against an in-bench track model.
// Depends on dtt_pkg and the detection_track_table_core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ActDetect = 1'b0;
  localparam logic ActFrame  = 1'b1;
  localparam logic RegDistance = 1'b0;
  localparam logic RegMinHits  = 1'b1;
  localparam int   Limit = 20000;
  localparam int   NTrk  = dtt_pkg::MaxTracks;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dtt_pkg::dtt_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dtt_pkg::dtt_out_t out_res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [9:0] cfg_data_i = '0;

  detection_track_table_core uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // track model
  logic       trk_valid [NTrk];
  logic       trk_pend  [NTrk];
  logic       trk_match [NTrk];
  logic [2:0] trk_label [NTrk];
  logic [4:0] trk_hist  [NTrk];
  logic [9:0] trk_x [NTrk], trk_y [NTrk], trk_w [NTrk], trk_h [NTrk];
  logic       dropped = 1'b0;
  logic [9:0] dist_lim = 10'd20;
  logic [2:0] hits_needed = 3'd3;

  dtt_pkg::dtt_in_t  pending_reqs[$];
  dtt_pkg::dtt_out_t expected_reports[$];
  int errors = 0, accepted_in = 0, reports_seen = 0, frames = 0, idle_cycles = 0;

  function automatic void add_req(dtt_pkg::dtt_in_t d);
    pending_reqs.insert(pending_reqs.size(), d);
  endfunction

  function automatic void add_report(dtt_pkg::dtt_out_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic int ones(logic [4:0] h);
    return h[0] + h[1] + h[2] + h[3] + h[4];
  endfunction

  function automatic bit is_same(dtt_pkg::dtt_in_t d, int i);
    int iw, ih, dx, dy;
    iw = ((int'(d.box_x) + d.box_width) < (int'(trk_x[i]) + trk_w[i]) ?
          (int'(d.box_x) + d.box_width) : (int'(trk_x[i]) + trk_w[i]))
         - (d.box_x > trk_x[i] ? int'(d.box_x) : int'(trk_x[i]));
    ih = ((int'(d.box_y) + d.box_height) < (int'(trk_y[i]) + trk_h[i]) ?
          (int'(d.box_y) + d.box_height) : (int'(trk_y[i]) + trk_h[i]))
         - (d.box_y > trk_y[i] ? int'(d.box_y) : int'(trk_y[i]));
    dx = int'(d.box_x) - int'(trk_x[i]);
    dy = int'(d.box_y) - int'(trk_y[i]);
    if (iw > 0 && ih > 0) return 1;
    return (dx * dx + dy * dy) < int'(dist_lim) * int'(dist_lim);
  endfunction

  task automatic track_update(dtt_pkg::dtt_in_t d);
    int used, k, c, n;
    bit hit;
    logic [4:0] h;
    dtt_pkg::dtt_out_t r;
    used = 0;
    hit = 0;
    if (d.action == ActDetect) begin
      for (int i = 0; i < NTrk; i++) begin
        if (trk_valid[i] || trk_pend[i]) used++;
        if (!trk_valid[i] || trk_match[i] || trk_label[i] != d.class_label) continue;
        if (is_same(d, i)) begin
          trk_x[i] = d.box_x; trk_y[i] = d.box_y;
          trk_w[i] = d.box_width; trk_h[i] = d.box_height;
          trk_hist[i] = {trk_hist[i][3:0], 1'b1};
          trk_match[i] = 1'b1;
          hit = 1;
        end
      end
      if (!hit) begin
        if (used < NTrk) begin
          trk_x[used] = d.box_x; trk_y[used] = d.box_y;
          trk_w[used] = d.box_width; trk_h[used] = d.box_height;
          trk_label[used] = d.class_label;
          trk_hist[used] = '0;
          trk_pend[used] = 1'b1;
        end else dropped = 1'b1;
      end
    end else begin
      k = 0;
      for (int i = 0; i < NTrk; i++) begin
        if (trk_valid[i]) h = trk_match[i] ? trk_hist[i] : {trk_hist[i][3:0], 1'b0};
        else if (trk_pend[i]) h = 5'd1;
        else continue;
        if (h == 0) continue;
        trk_x[k] = trk_x[i]; trk_y[k] = trk_y[i]; trk_w[k] = trk_w[i]; trk_h[k] = trk_h[i];
        trk_label[k] = trk_label[i];
        trk_hist[k] = h;
        k++;
      end
      for (int i = 0; i < NTrk; i++) begin
        trk_valid[i] = (i < k);
        trk_match[i] = 1'b0;
        trk_pend[i] = 1'b0;
      end
      n = 0;
      for (int i = 0; i < k; i++) begin
        c = ones(trk_hist[i]);
        if (c < hits_needed) continue;
        if (n > 0) add_report(r);
        r = '{present: 1'b1, out_x: trk_x[i], out_y: trk_y[i], out_width: trk_w[i],
              out_height: trk_h[i], out_label: trk_label[i], hit_count: 3'(c),
              overflow: dropped, last: 1'b0};
        n++;
      end
      if (n == 0) begin
        r = '0;
        r.overflow = dropped;
      end
      r.last = 1'b1;
      add_report(r);
      dropped = 1'b0;
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        track_update(in_req_i);
        accepted_in <= accepted_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_req_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          in_gap <= gap_len();
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk_i) begin
    dtt_pkg::dtt_out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        reports_seen <= reports_seen + 1;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report %h", $time, out_res_o);
          errors++;
        end else begin
          e = expected_reports.pop_front();
          if (out_res_o !== e) begin
            $display("%0t: report mismatch expected %h actual %h", $time, e, out_res_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Limit) begin
      $display("FAIL detection_track_table_core");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegDistance) dist_lim = val;
    else hits_needed = val[2:0];
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_reports.size() == 0);
    repeat (2 * NTrk + 8) @(posedge clk_i);
  endtask

  function automatic dtt_pkg::dtt_in_t det(logic [9:0] x, logic [9:0] y, logic [9:0] w,
                                           logic [9:0] h, logic [2:0] l);
    return '{action: ActDetect, box_x: x, box_y: y, box_width: w, box_height: h,
             class_label: l};
  endfunction

  function automatic dtt_pkg::dtt_in_t frame_end();
    dtt_pkg::dtt_in_t d;
    d = '0;
    d.action = ActFrame;
    return d;
  endfunction

  task automatic random_frames(int items);
    int nd;
    logic [2:0] l;
    logic [9:0] x, y;
    while (items > 0) begin
      nd = $urandom_range(0, 10) == 0 ? $urandom_range(14, 20) : $urandom_range(0, 6);
      for (int j = 0; j < nd; j++) begin
        l = 3'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) begin
          add_req(det(10'($urandom), 10'($urandom), 10'($urandom),
                      10'($urandom), 3'($urandom)));
        end else begin
          x = 10'(100 * l + $urandom_range(0, 30));
          y = 10'(100 * j + $urandom_range(0, 30));
          add_req(det(x, y, 10'($urandom_range(0, 40)),
                      10'($urandom_range(0, 40)), l));
        end
      end
      add_req(frame_end());
      frames++;
      items -= nd + 1;
    end
  endtask

  initial begin
    for (int i = 0; i < NTrk; i++) begin
      trk_valid[i] = 0; trk_pend[i] = 0; trk_match[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, zero-size boxes, overlap, corner distance, overflow
    add_req(frame_end());
    add_req(det(10'd0, 10'd0, 10'd1023, 10'd1023, 3'd7));
    add_req(det(10'd1023, 10'd1023, 10'd0, 10'd0, 3'd0));
    add_req(frame_end());
    add_req(det(10'd5, 10'd5, 10'd3, 10'd3, 3'd7));
    add_req(det(10'd1010, 10'd1015, 10'd0, 10'd5, 3'd0));
    add_req(frame_end());
    add_req(det(10'd6, 10'd6, 10'd2, 10'd2, 3'd7));
    add_req(det(10'd1023, 10'd1023, 10'd0, 10'd0, 3'd0));
    add_req(frame_end());
    for (int i = 0; i < 18; i++)
      add_req(det(10'(i * 50), 10'(500), 10'd4, 10'd4, 3'd2));
    add_req(frame_end());
    drain();
    write_reg(RegMinHits, 10'd0);
    write_reg(RegDistance, 10'd1023);
    random_frames(70);
    drain();
    write_reg(RegDistance, 10'd0);
    write_reg(RegMinHits, 10'd5);
    random_frames(60);
    drain();
    write_reg(RegMinHits, 10'd7);
    write_reg(RegDistance, 10'd60);
    random_frames(40);
    drain();
    write_reg(RegMinHits, 10'd1);
    write_reg(RegDistance, 10'd20);
    random_frames(80);
    drain();
    write_reg(RegMinHits, 10'd3);
    random_frames(50);
    drain();
    $display("Ran %0d requests over %0d frames with random gaps and stalls.", accepted_in,
             frames);
    $display("Checked %0d reports across six register settings.", reports_seen);
    if (errors == 0) $display("PASS detection_track_table_core");
    else $display("FAIL detection_track_table_core");
    $finish;
  end
endmodule
